### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dcrgb_pkg.sv
`timescale 1ns / 1ps
package dcrgb_pkg;

  localparam int unsigned NumColors = 3;

  localparam logic [7:0] LenMinForward = 8'd6;
  localparam logic [7:0] LenTrim       = 8'd3;
  localparam logic [7:0] PeriodReset   = 8'd255;
  localparam logic [7:0] ByteZero      = 8'h00;

  // Duty byte positions inside a packet
  localparam logic [7:0] PosRed   = 8'd1;
  localparam logic [7:0] PosGreen = 8'd2;
  localparam logic [7:0] PosBlue  = 8'd3;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdTick = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic                 tx_valid;
    logic [7:0]           tx_byte;
    logic [NumColors-1:0] levels;
  } result_t;

endpackage

### rtl/dcrgb_intf.sv
`timescale 1ns / 1ps
// Request channel into the node.
interface dcrgb_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] cmd;
  logic [7:0] rx_byte;

  modport source (output valid, cmd, rx_byte, input ready);
  modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

// Result channel out of the node.
interface dcrgb_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       red_level;
  logic       green_level;
  logic       blue_level;

  modport source (output valid, tx_valid, tx_byte, red_level, green_level, blue_level,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, red_level, green_level, blue_level,
                  output ready);
endinterface

### rtl/dcrgb_in_stage.sv
`timescale 1ns / 1ps
module dcrgb_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  dcrgb_in_if.sink        req,
  output logic            valid_o,
  output dcrgb_pkg::item_t item_o
);
  import dcrgb_pkg::*;

  logic  valid_q;
  item_t item_q;

  // Take a new request when the stage is empty or the held one moves on this cycle.
  assign req.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req.ready) begin
      valid_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.ready && req.valid) begin
      item_q.cmd     <= cmd_e'(req.cmd);
      item_q.rx_byte <= req.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### rtl/dcrgb_core.sv
`timescale 1ns / 1ps
module dcrgb_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [7:0]       cfg_wdata_i,
  input  logic             item_valid_i,
  input  dcrgb_pkg::item_t item_i,
  output logic             advance_o,
  dcrgb_out_if.source      rsp
);
  import dcrgb_pkg::*;

  logic [7:0]           period_q;
  logic [7:0]           packet_size_q, packet_size_d;
  logic [7:0]           bytes_left_q, bytes_left_d;
  logic [7:0]           duty_q [NumColors];
  logic [7:0]           duty_d [NumColors];
  logic [7:0]           counter_q, counter_d;
  logic [NumColors-1:0] levels_q, levels_d;
  logic                 out_valid_q;
  result_t              res_q, res_d;

  logic       fire;
  logic [7:0] pos;
  logic [7:0] b;
  logic       is_duty;
  logic       is_start;

  assign advance_o = !out_valid_q || rsp.ready;
  assign fire      = item_valid_i && advance_o;

  assign b        = item_i.rx_byte;
  assign pos      = packet_size_q - bytes_left_q;
  assign is_duty  = (pos == PosRed) || (pos == PosGreen) || (pos == PosBlue);
  // A new length byte: idle between packets, or a short packet's spare byte.
  assign is_start = (bytes_left_q == ByteZero) ||
                    (!is_duty && (packet_size_q < LenMinForward));

  always_comb begin
    packet_size_d = packet_size_q;
    bytes_left_d  = bytes_left_q;
    counter_d     = counter_q;
    levels_d      = levels_q;
    for (int i = 0; i < NumColors; i++) begin
      duty_d[i] = duty_q[i];
    end
    res_d.tx_valid = 1'b0;
    res_d.tx_byte  = ByteZero;

    case (item_i.cmd)
      CmdByte: begin
        if (is_start) begin
          packet_size_d  = b + 8'd1;
          bytes_left_d   = b;
          res_d.tx_valid = 1'b1;
          res_d.tx_byte  = (b >= LenMinForward) ? b - LenTrim : ByteZero;
        end else begin
          bytes_left_d = bytes_left_q - 8'd1;
          if (pos == PosRed) begin
            duty_d[0] = b;
          end else if (pos == PosGreen) begin
            duty_d[1] = b;
          end else if (pos == PosBlue) begin
            duty_d[2] = b;
          end else begin
            res_d.tx_valid = 1'b1;
            res_d.tx_byte  = b;
          end
        end
      end
      CmdTick: begin
        counter_d = (counter_q >= period_q) ? ByteZero : counter_q + 8'd1;
        for (int i = 0; i < NumColors; i++) begin
          if (counter_d == period_q) begin
            levels_d[i] = 1'b0;
          end else if (counter_d == duty_q[i]) begin
            levels_d[i] = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_d.levels = levels_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= PeriodReset;
      packet_size_q <= ByteZero;
      bytes_left_q  <= ByteZero;
      counter_q     <= ByteZero;
      levels_q      <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < NumColors; i++) begin
        duty_q[i] <= ByteZero;
      end
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (advance_o) begin
        out_valid_q <= item_valid_i;
      end
      if (fire) begin
        packet_size_q <= packet_size_d;
        bytes_left_q  <= bytes_left_d;
        counter_q     <= counter_d;
        levels_q      <= levels_d;
        for (int i = 0; i < NumColors; i++) begin
          duty_q[i] <= duty_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.tx_valid    = res_q.tx_valid;
  assign rsp.tx_byte     = res_q.tx_byte;
  assign rsp.red_level   = res_q.levels[0];
  assign rsp.green_level = res_q.levels[1];
  assign rsp.blue_level  = res_q.levels[2];

endmodule

### rtl/daisy_chain_rgb_pwm_node.sv
`timescale 1ns / 1ps
// A request passes through the input register, then the result register.
// Throughput: 1 request per cycle; only a stalled result port slows intake.
// The pace is set by the result register handshake: the input register moves
// forward whenever the result register is empty or being taken.
// Reset (async, active low): period 255, duties, counter, packet state, levels 0.
module daisy_chain_rgb_pwm_node (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,     // PWM period write
  input  logic [7:0]  cfg_wdata_i,
  dcrgb_in_if.sink    req_i,        // serial byte or PWM tick
  dcrgb_out_if.source rsp_o         // forwarded byte and color levels
);
  import dcrgb_pkg::*;

  logic  item_valid;
  item_t item;
  logic  advance;

  // Stage 1: registers the request (cmd and byte).
  dcrgb_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req       (req_i),
    .valid_o   (item_valid),
    .item_o    (item)
  );

  // Stage 2: packet parser and PWM update in one pass, with the node state
  // (packet size, bytes left, duties, counter, levels) updated as the
  // result is loaded into the output register.
  dcrgb_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_o    (advance),
    .rsp          (rsp_o)
  );

endmodule

### rtl/dcrgb_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dcrgb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_tx_valid_i,
  input logic [7:0] rsp_tx_byte_i,
  input logic       rsp_red_i,
  input logic       rsp_green_i,
  input logic       rsp_blue_i
);

  `ASSERT_ANY(a_rsp_idle_after_reset, clk_i, !rst_ni |=> !rsp_valid_i, "result valid after reset")
  `ASSERT_RUN(a_req_gives_rsp, clk_i, rst_ni, req_valid_i && req_ready_i |-> ##2 rsp_valid_i, "accepted request has no result two cycles later")
  `ASSERT_RUN(a_no_tx_zero_byte, clk_i, rst_ni, rsp_valid_i && !rsp_tx_valid_i |-> rsp_tx_byte_i == 8'h00, "tx byte nonzero without tx valid")
  `ASSERT_RUN(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_tx_valid_i) && $stable(rsp_tx_byte_i) && $stable(rsp_red_i) && $stable(rsp_green_i) && $stable(rsp_blue_i), "stalled result changed")

endmodule

bind daisy_chain_rgb_pwm_node dcrgb_checker u_dcrgb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_tx_valid_i (rsp_o.tx_valid),
  .rsp_tx_byte_i  (rsp_o.tx_byte),
  .rsp_red_i      (rsp_o.red_level),
  .rsp_green_i    (rsp_o.green_level),
  .rsp_blue_i     (rsp_o.blue_level)
);
